FILE: hdl/sq8_vector_distance_core_defines.svh
// assertion macros shared by the sq8 vector distance core
`ifndef SQ8_VECTOR_DISTANCE_CORE_DEFINES_SVH
`define SQ8_VECTOR_DISTANCE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset on clk
`define SQ8_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("sq8 core assertion failed");

// next-cycle implication, checked out of reset on clk
`define SQ8_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("sq8 core assertion failed");

`endif

FILE: hdl/sq8vd_pkg.sv
// types, constants and helpers shared by the sq8 vector distance core
`timescale 1ns / 1ps

package sq8vd_pkg;

  localparam int FUNC_W = 2;
  localparam int DATA_W = 32;
  localparam int CODE_W = 8;
  localparam int DIST_W = 64;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CMD_DEPTH_DEF = 4;
  localparam int RES_DEPTH_DEF = 2;

  // exact divide by 255: 32-bit and 16-bit reciprocal constants
  localparam logic [31:0] DIV255_M32  = 32'h8080_8081;
  localparam int          DIV255_SH32 = 39;
  localparam logic [15:0] DIV255_M16  = 16'h8081;
  localparam int          DIV255_SH16 = 23;
  localparam logic [15:0] DIV255_BIAS = 16'd127;
  localparam int          RQ_W        = 24;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_QUERY_IP = 2'd0,
    FUNC_QUERY_L2 = 2'd1,
    FUNC_CODE_IP  = 2'd2,
    FUNC_CODE_L2  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIV,
    BK_REM,
    BK_QUO,
    BK_DEQ,
    BK_OPS,
    BK_MUL,
    BK_RND,
    BK_ACC
  } bk_state_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                     use_query;
    logic                     square;
    logic                     rng_neg;
    logic [DATA_W-1:0]        rng_mag;
    logic signed [DATA_W-1:0] query;
    logic [CODE_W-1:0]        code_a;
    logic [CODE_W-1:0]        code_b;
    logic signed [DATA_W-1:0] lb;
    logic                     last;
  } cmd_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic                     overflowed;
  } res_t;

  function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] u;
    u = v;
    return v[DATA_W-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

FILE: hdl/sq8_vector_distance_core.sv
// top level of the sq8 vector distance core
// Streams one vector dimension per input word and accumulates either the inner product or
// the squared L2 distance between a Q16.16 query and an 8-bit scalar-quantized code, or
// between two codes of the same dimension (func selects which). Each code is dequantized as
// lower_bound + round(code * range_width / 255), clamped to 32 bits. Products are rounded
// back to FRAC_BITS fraction bits (half away from zero) and summed in a saturating 64-bit
// accumulator; a word with last_element set emits the sum and the sticky overflow flag and
// clears both. Both sides behave as queues: push while full is low, pop while empty is low.
// The back end handles one word at a time: it fetches the word from the command queue, then
// runs eight sequencer steps (divide-by-255 split, remainder, quotient, clamp, operand
// select, multiply, round, accumulate) before it takes the next word; the accumulate step
// holds while a last word meets a full result queue. With the queues empty, out_empty drops
// once the accumulate step of the last word of a vector pushes its result. The command queue
// takes up to CMD_DEPTH words ahead of the back end, and the result queue holds RES_DEPTH
// results, so a stalled consumer only stops the back end once the result queue is full.
`timescale 1ns / 1ps

module sq8_vector_distance_core #(
  parameter int FRAC_BITS = sq8vd_pkg::FRAC_BITS_DEF,
  parameter int CMD_DEPTH = sq8vd_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH = sq8vd_pkg::RES_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word side
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [sq8vd_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [sq8vd_pkg::DATA_W-1:0] in_query_value,
  input  logic [sq8vd_pkg::CODE_W-1:0]        in_code_a,
  input  logic [sq8vd_pkg::CODE_W-1:0]        in_code_b,
  input  logic signed [sq8vd_pkg::DATA_W-1:0] in_lower_bound,
  input  logic signed [sq8vd_pkg::DATA_W-1:0] in_range_width,
  input  logic                                in_last_element,
  // result word side
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [sq8vd_pkg::DIST_W-1:0] out_distance,
  output logic                                out_overflowed
);
  import sq8vd_pkg::*;

  // front to command queue
  logic q_push, q_full;
  cmd_t q_wdata;

  // command queue to back end
  logic cmd_empty, cmd_pop;
  cmd_t cmd_rdata;

  // back end to result queue
  logic res_push, res_full;
  res_t res_wdata, res_rdata;

  sq8vd_front u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_query_value  (in_query_value),
    .in_code_a       (in_code_a),
    .in_code_b       (in_code_b),
    .in_lower_bound  (in_lower_bound),
    .in_range_width  (in_range_width),
    .in_last_element (in_last_element),
    .q_push          (q_push),
    .q_full          (q_full),
    .q_data          (q_wdata)
  );

  // decouples word intake from the sequencer
  sq8vd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_rdata)
  );

  sq8vd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_rdata),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  // finished results wait here for the consumer
  sq8vd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_wdata),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (res_rdata)
  );

  assign out_distance   = res_rdata.distance;
  assign out_overflowed = res_rdata.overflowed;

endmodule

FILE: hdl/sq8vd_fifo.sv
// small register queue with push/full and pop/empty sides
`timescale 1ns / 1ps

module sq8vd_fifo #(
  parameter int WIDTH = $bits(sq8vd_pkg::cmd_t),
  parameter int DEPTH = sq8vd_pkg::CMD_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  import sq8vd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: hdl/sq8vd_front.sv
// front end: takes input words and classifies them for the back end
`timescale 1ns / 1ps

module sq8vd_front (
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [sq8vd_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [sq8vd_pkg::DATA_W-1:0] in_query_value,
  input  logic [sq8vd_pkg::CODE_W-1:0]        in_code_a,
  input  logic [sq8vd_pkg::CODE_W-1:0]        in_code_b,
  input  logic signed [sq8vd_pkg::DATA_W-1:0] in_lower_bound,
  input  logic signed [sq8vd_pkg::DATA_W-1:0] in_range_width,
  input  logic                                in_last_element,
  output logic                                q_push,
  input  logic                                q_full,
  output sq8vd_pkg::cmd_t                     q_data
);
  import sq8vd_pkg::*;

  logic use_query, square;

  // first operand source and term kind
  always_comb begin
    case (func_t'(in_func))
      FUNC_QUERY_IP: begin
        use_query = 1'b1;
        square    = 1'b0;
      end
      FUNC_QUERY_L2: begin
        use_query = 1'b1;
        square    = 1'b1;
      end
      FUNC_CODE_IP: begin
        use_query = 1'b0;
        square    = 1'b0;
      end
      FUNC_CODE_L2: begin
        use_query = 1'b0;
        square    = 1'b1;
      end
      default: begin
        use_query = 1'b0;
        square    = 1'b0;
      end
    endcase
  end

  assign in_full = q_full;
  assign q_push  = in_push;

  always_comb begin
    q_data.use_query = use_query;
    q_data.square    = square;
    q_data.rng_neg   = in_range_width[DATA_W-1];
    q_data.rng_mag   = abs32(in_range_width);
    q_data.query     = in_query_value;
    q_data.code_a    = in_code_a;
    q_data.code_b    = in_code_b;
    q_data.lb        = in_lower_bound;
    q_data.last      = in_last_element;
  end

endmodule

FILE: hdl/sq8vd_back.sv
// back end: dequantize, form the term, round and accumulate
`timescale 1ns / 1ps
`include "sq8_vector_distance_core_defines.svh"

module sq8vd_back #(
  parameter int FRAC_BITS = sq8vd_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  input  sq8vd_pkg::cmd_t cmd_data,
  input  logic            res_full,
  output logic            res_push,
  output sq8vd_pkg::res_t res_data
);
  import sq8vd_pkg::*;

  localparam logic [DIST_W:0] RND_HALF = (DIST_W+1)'(1) << (FRAC_BITS - 1);

  bk_state_t state_r, state_nxt;
  logic      acc_done;

  cmd_t                     cmd_r;
  logic [RQ_W-1:0]          rq_r;
  logic [15:0]              ya_r, yb_r;
  logic [DATA_W-1:0]        pa_r, pb_r;
  logic [DATA_W-1:0]        mag_a_r, mag_b_r;
  logic signed [DATA_W-1:0] va_r, vb_r;
  logic [DATA_W-1:0]        ma_r, mb_r;
  logic                     neg_r;
  logic [DIST_W-1:0]        prod_r;
  logic signed [DIST_W-1:0] term_r;
  logic signed [DIST_W-1:0] acc_r;
  logic                     sticky_r;

  logic [2*DATA_W-1:0]      div_prod;
  logic [DATA_W-1:0]        rem_full;
  logic [CODE_W-1:0]        rr;
  logic [DATA_W-1:0]        qa_prod, qb_prod;
  logic signed [DATA_W-1:0] op_x, op_y;
  logic [DATA_W:0]          diff, dmag;
  logic [DIST_W:0]          rsum, rshift;
  logic [DIST_W:0]          sum;
  logic                     ovf;
  logic signed [DIST_W-1:0] sat;
  logic                     sticky_acc;

  // lower bound plus signed magnitude, clamped to 32 bits
  function automatic logic signed [DATA_W-1:0] deq_clamp(
    input logic signed [DATA_W-1:0] lb,
    input logic [DATA_W-1:0]        mag,
    input logic                     neg
  );
    logic [DATA_W+1:0] m;
    logic [DATA_W+1:0] s;
    m = {2'b00, mag};
    s = {{2{lb[DATA_W-1]}}, lb} + (neg ? (~m + 1'b1) : m);
    if (s[DATA_W+1:DATA_W-1] == 3'b000 || s[DATA_W+1:DATA_W-1] == 3'b111) begin
      return $signed(s[DATA_W-1:0]);
    end else if (s[DATA_W+1]) begin
      return DATA_MIN;
    end else begin
      return DATA_MAX;
    end
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!cmd_empty) state_nxt = BK_DIV;
      BK_DIV:  state_nxt = BK_REM;
      BK_REM:  state_nxt = BK_QUO;
      BK_QUO:  state_nxt = BK_DEQ;
      BK_DEQ:  state_nxt = BK_OPS;
      BK_OPS:  state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_RND;
      BK_RND:  state_nxt = BK_ACC;
      BK_ACC:  if (!(cmd_r.last && res_full)) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    acc_done = 1'b0;
    case (state_r)
      BK_IDLE: cmd_pop = ~cmd_empty;
      BK_ACC: begin
        res_push = cmd_r.last & ~res_full;
        acc_done = ~(cmd_r.last & res_full);
      end
      default: begin
        cmd_pop  = 1'b0;
        res_push = 1'b0;
        acc_done = 1'b0;
      end
    endcase
  end

  // range magnitude split as 255 * rq + rr
  assign div_prod = (2*DATA_W)'(cmd_r.rng_mag) * (2*DATA_W)'(DIV255_M32);
  assign rem_full = cmd_r.rng_mag - ({rq_r, 8'b0} - {8'b0, rq_r});
  assign rr       = rem_full[CODE_W-1:0];
  assign qa_prod  = {16'b0, ya_r} * {16'b0, DIV255_M16};
  assign qb_prod  = {16'b0, yb_r} * {16'b0, DIV255_M16};

  // operand selection
  assign op_x = cmd_r.use_query ? cmd_r.query : va_r;
  assign op_y = cmd_r.use_query ? va_r : vb_r;
  assign diff = {op_x[DATA_W-1], op_x} - {op_y[DATA_W-1], op_y};
  assign dmag = diff[DATA_W] ? (~diff + 1'b1) : diff;

  // rounding half away from zero on the magnitude
  assign rsum   = {1'b0, prod_r} + RND_HALF;
  assign rshift = rsum >> FRAC_BITS;

  // saturating accumulate
  assign sum        = {acc_r[DIST_W-1], acc_r} + {term_r[DIST_W-1], term_r};
  assign ovf        = sum[DIST_W] ^ sum[DIST_W-1];
  assign sat        = ovf ? (sum[DIST_W] ? DIST_MIN : DIST_MAX) : $signed(sum[DIST_W-1:0]);
  assign sticky_acc = sticky_r | ovf;

  assign res_data.distance   = sat;
  assign res_data.overflowed = sticky_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      acc_r    <= '0;
      sticky_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc_done) begin
        acc_r    <= cmd_r.last ? '0 : sat;
        sticky_r <= cmd_r.last ? 1'b0 : sticky_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd_data;
    end
    case (state_r)
      BK_DIV: rq_r <= div_prod[DIV255_SH32 +: RQ_W];
      BK_REM: begin
        ya_r <= 16'({8'b0, cmd_r.code_a} * {8'b0, rr}) + DIV255_BIAS;
        yb_r <= 16'({8'b0, cmd_r.code_b} * {8'b0, rr}) + DIV255_BIAS;
        pa_r <= {24'b0, cmd_r.code_a} * {8'b0, rq_r};
        pb_r <= {24'b0, cmd_r.code_b} * {8'b0, rq_r};
      end
      BK_QUO: begin
        mag_a_r <= pa_r + {24'b0, qa_prod[DIV255_SH16 +: CODE_W]};
        mag_b_r <= pb_r + {24'b0, qb_prod[DIV255_SH16 +: CODE_W]};
      end
      BK_DEQ: begin
        va_r <= deq_clamp(cmd_r.lb, mag_a_r, cmd_r.rng_neg);
        vb_r <= deq_clamp(cmd_r.lb, mag_b_r, cmd_r.rng_neg);
      end
      BK_OPS: begin
        if (cmd_r.square) begin
          ma_r  <= dmag[DATA_W-1:0];
          mb_r  <= dmag[DATA_W-1:0];
          neg_r <= 1'b0;
        end else begin
          ma_r  <= abs32(op_x);
          mb_r  <= abs32(op_y);
          neg_r <= op_x[DATA_W-1] ^ op_y[DATA_W-1];
        end
      end
      BK_MUL: prod_r <= DIST_W'(ma_r) * DIST_W'(mb_r);
      BK_RND: term_r <= neg_r ? $signed(~rshift[DIST_W-1:0] + 1'b1)
                              : $signed(rshift[DIST_W-1:0]);
      default: begin
      end
    endcase
  end

  `SQ8_ASSERT_IMP(a_pop_only_idle, cmd_pop, state_r == BK_IDLE)
  `SQ8_ASSERT_NXT(a_pop_starts_item, cmd_pop, state_r == BK_DIV)
  `SQ8_ASSERT_IMP(a_push_only_last, res_push, state_r == BK_ACC && cmd_r.last)
  `SQ8_ASSERT_NXT(a_clear_after_emit, res_push, acc_r == '0 && !sticky_r)

endmodule

FILE: verif/sq8_vector_distance_checker.sv
// result predictor and checker for the sq8 vector distance core
`timescale 1ns / 1ps

module sq8_vector_distance_checker #(
  parameter int FRAC_BITS = sq8vd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic                                in_full,
  input  logic [sq8vd_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [sq8vd_pkg::DATA_W-1:0] in_query_value,
  input  logic [sq8vd_pkg::CODE_W-1:0]        in_code_a,
  input  logic [sq8vd_pkg::CODE_W-1:0]        in_code_b,
  input  logic signed [sq8vd_pkg::DATA_W-1:0] in_lower_bound,
  input  logic signed [sq8vd_pkg::DATA_W-1:0] in_range_width,
  input  logic                                in_last_element,
  input  logic                                out_empty,
  input  logic                                out_pop,
  input  logic signed [sq8vd_pkg::DIST_W-1:0] out_distance,
  input  logic                                out_overflowed,
  output int                                  pending,
  output int                                  errors
);
  import sq8vd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  res_t   expected_sums[$];
  longint run_sum;
  bit     run_sat;

  // lower + round(code * span / 255), clamped to 32 bits
  function automatic longint dequantize_code(input logic [CODE_W-1:0] code, input longint lower,
                                             input longint span);
    longint      prod;
    longint      quot;
    longint      val;
    logic [63:0] mag;
    prod = longint'({56'd0, code}) * span;
    mag  = (prod < 0) ? -prod : prod;
    quot = longint'((mag + 64'd127) / 64'd255);
    if (prod < 0) quot = -quot;
    val = lower + quot;
    if (val > longint'(DATA_MAX)) val = longint'(DATA_MAX);
    if (val < longint'(DATA_MIN)) val = longint'(DATA_MIN);
    return val;
  endfunction

  // drop FRAC_BITS, half away from zero
  function automatic longint round_shift(input logic [63:0] mag, input bit neg);
    logic [63:0] r;
    r = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint fixed_product(input longint a, input longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    return round_shift(ma * mb, (a < 0) != (b < 0));
  endfunction

  function automatic longint fixed_square(input longint d);
    logic [63:0] m;
    m = (d < 0) ? -d : d;
    return round_shift(m * m, 1'b0);
  endfunction

  function automatic longint dimension_term(input func_t f, input longint q, input longint va,
                                            input longint vb);
    case (f)
      FUNC_QUERY_IP: return fixed_product(q, va);
      FUNC_QUERY_L2: return fixed_square(q - va);
      FUNC_CODE_IP:  return fixed_product(va, vb);
      default:       return fixed_square(va - vb);
    endcase
  endfunction

  always @(posedge clk) begin : track
    longint va;
    longint vb;
    longint term;
    res_t   want;
    res_t   got;
    int     added;
    int     removed;
    if (!rst_n) begin
      expected_sums.delete();
      run_sum = 0;
      run_sat = 1'b0;
      pending <= 0;
    end else begin
      added   = 0;
      removed = 0;
      if (in_push && !in_full) begin
        va   = dequantize_code(in_code_a, longint'(in_lower_bound), longint'(in_range_width));
        vb   = dequantize_code(in_code_b, longint'(in_lower_bound), longint'(in_range_width));
        term = dimension_term(func_t'(in_func), longint'(in_query_value), va, vb);
        if (term > 0 && run_sum > longint'(DIST_MAX) - term) begin
          run_sum = longint'(DIST_MAX);
          run_sat = 1'b1;
        end else if (term < 0 && run_sum < longint'(DIST_MIN) - term) begin
          run_sum = longint'(DIST_MIN);
          run_sat = 1'b1;
        end else begin
          run_sum = run_sum + term;
        end
        if (in_last_element) begin
          want.distance   = run_sum;
          want.overflowed = run_sat;
          expected_sums.push_back(want);
          added   = 1;
          run_sum = 0;
          run_sat = 1'b0;
        end
      end
      if (out_pop && !out_empty) begin
        got.distance   = out_distance;
        got.overflowed = out_overflowed;
        if (expected_sums.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("%0t: result word with nothing expected: distance %0d overflowed %0b",
                     $realtime, got.distance, got.overflowed);
          errors <= errors + 1;
        end else begin
          want    = expected_sums.pop_front();
          removed = 1;
          if (got.distance !== want.distance || got.overflowed !== want.overflowed) begin
            if (errors < REPORT_LIMIT)
              $display("%0t: mismatch: distance exp %0d got %0d, overflowed exp %0b got %0b",
                       $realtime, want.distance, got.distance, want.overflowed,
                       got.overflowed);
            errors <= errors + 1;
          end
        end
      end
      pending <= pending + added - removed;
    end
  end

endmodule

FILE: verif/tb_sq8_vector_distance_core.sv
// stimulus and verdict for the sq8 vector distance core, checked against a predictor
`timescale 1ns / 1ps

module tb_sq8_vector_distance_core;
  import sq8vd_pkg::*;

  localparam int RESET_CYCLES    = 6;
  localparam int RANDOM_WORDS    = 800;
  // tail of the random part that runs with no gaps on either side
  localparam int CALM_WORDS      = 150;
  // max-size squares near 2^48 each: a long vector whose sum climbs far past 32 bits
  localparam int SAT_WORDS       = 48;
  localparam int PRESSURE_WORDS  = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  // tail long enough for the back end to work through a full command queue, plus margin
  localparam int DRAIN_CYCLES    = 64;
  // longest legal quiet stretch is the hold-off, well below this
  localparam int STALL_LIMIT     = 4000;

  // one dimension as the sender sees it
  typedef struct {
    func_t                    func;
    logic signed [DATA_W-1:0] query;
    logic [CODE_W-1:0]        code_a;
    logic [CODE_W-1:0]        code_b;
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] span;
    logic                     last;
  } dim_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic [FUNC_W-1:0]        in_func = FUNC_QUERY_IP;
  logic signed [DATA_W-1:0] in_query_value = '0;
  logic [CODE_W-1:0]        in_code_a = '0;
  logic [CODE_W-1:0]        in_code_b = '0;
  logic signed [DATA_W-1:0] in_lower_bound = '0;
  logic signed [DATA_W-1:0] in_range_width = '0;
  logic                     in_last_element = 1'b0;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic signed [DIST_W-1:0] out_distance;
  logic                     out_overflowed;

  int pending;
  int errors;
  int idle_cycles = 0;

  // written by the stimulus process, read by the result sink
  bit jitter_on = 1'b0;
  bit hold_off_go = 1'b0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sq8_vector_distance_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_query_value (in_query_value),
    .in_code_a      (in_code_a),
    .in_code_b      (in_code_b),
    .in_lower_bound (in_lower_bound),
    .in_range_width (in_range_width),
    .in_last_element(in_last_element),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_distance   (out_distance),
    .out_overflowed (out_overflowed)
  );

  // watches both sides, predicts each vector sum and compares
  sq8_vector_distance_checker sum_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_query_value (in_query_value),
    .in_code_a      (in_code_a),
    .in_code_b      (in_code_b),
    .in_lower_bound (in_lower_bound),
    .in_range_width (in_range_width),
    .in_last_element(in_last_element),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_distance   (out_distance),
    .out_overflowed (out_overflowed),
    .pending        (pending),
    .errors         (errors)
  );

  // Q16.16 value biased toward the extremes and small magnitudes
  function automatic logic signed [DATA_W-1:0] pick_fixed();
    case ($urandom_range(0, 9))
      0:       return DATA_MIN;
      1:       return DATA_MAX;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic dim_word_t word_of(input func_t f, input logic signed [DATA_W-1:0] q,
                                        input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
                                        input logic signed [DATA_W-1:0] lower,
                                        input logic signed [DATA_W-1:0] span, input logic last);
    dim_word_t w;
    w.func   = f;
    w.query  = q;
    w.code_a = a;
    w.code_b = b;
    w.lower  = lower;
    w.span   = span;
    w.last   = last;
    return w;
  endfunction

  function automatic dim_word_t make_word(input func_t f, input logic last);
    return word_of(f, pick_fixed(), pick_code(), pick_code(), pick_fixed(), pick_fixed(), last);
  endfunction

  // offer one word and return at the edge that takes it; push stays high
  task automatic push_word(input dim_word_t w);
    in_func         <= w.func;
    in_query_value  <= w.query;
    in_code_a       <= w.code_a;
    in_code_b       <= w.code_b;
    in_lower_bound  <= w.lower;
    in_range_width  <= w.span;
    in_last_element <= w.last;
    in_push         <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic sender_gap(input int cycles);
    in_push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (jitter_on && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 3));
  endtask

  // stop sending until every expected sum has come back
  task automatic drain_pause();
    in_push <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // no word moved on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: one long hold-off on request, short random stalls while jitter is on
  initial begin : result_sink
    bit held;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_go && !held) begin
        held = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (jitter_on && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    dim_word_t w;
    func_t     vec_func;
    int        sent;
    int        vec_len;
    bit        mixed;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of every mode, one dimension per vector
    push_word(word_of(FUNC_QUERY_IP, DATA_MAX, 8'hFF, 8'h00, 32'sd0, DATA_MAX, 1'b1));
    push_word(word_of(FUNC_QUERY_IP, DATA_MIN, 8'hFF, 8'hFF, DATA_MIN, DATA_MAX, 1'b1));
    // widest query difference: min query against a code pinned at max
    push_word(word_of(FUNC_QUERY_L2, DATA_MIN, 8'h00, 8'h00, DATA_MAX, 32'sd0, 1'b1));
    // dequantized code clamps low
    push_word(word_of(FUNC_QUERY_L2, DATA_MAX, 8'hFF, 8'h00, DATA_MIN, DATA_MIN, 1'b1));
    push_word(word_of(FUNC_CODE_IP, 32'sd0, 8'h00, 8'hFF, DATA_MIN, DATA_MIN, 1'b1));
    // both codes clamp high
    push_word(word_of(FUNC_CODE_IP, 32'sd0, 8'hFF, 8'hFF, DATA_MAX, DATA_MAX, 1'b1));
    push_word(word_of(FUNC_CODE_L2, 32'sd0, 8'hFF, 8'h00, 32'sd0, DATA_MIN, 1'b1));
    // query ignored in code-code modes: same sum both times
    push_word(word_of(FUNC_CODE_L2, DATA_MIN, 8'h5A, 8'hA5, 32'sh0001_8000, 32'sh0004_0000,
                      1'b1));
    push_word(word_of(FUNC_CODE_L2, DATA_MAX, 8'h5A, 8'hA5, 32'sh0001_8000, 32'sh0004_0000,
                      1'b1));
    // second code ignored in query modes
    push_word(word_of(FUNC_QUERY_IP, 32'sh0003_0000, 8'h80, 8'h00, -32'sh0001_0000,
                      32'sh0002_0000, 1'b1));
    push_word(word_of(FUNC_QUERY_IP, 32'sh0003_0000, 8'h80, 8'hFF, -32'sh0001_0000,
                      32'sh0002_0000, 1'b1));
    // product lands exactly on a half lsb, both signs
    push_word(word_of(FUNC_QUERY_IP, 32'sh0000_8000, 8'h00, 8'h00, 32'sd1, 32'sd0, 1'b1));
    push_word(word_of(FUNC_QUERY_IP, -32'sh0000_8000, 8'h00, 8'h00, 32'sd1, 32'sd0, 1'b1));
    // negative range: quotient rounds to -1, then to 0
    push_word(word_of(FUNC_QUERY_IP, 32'sh0001_0000, 8'h01, 8'h00, 32'sd0, -32'sd128, 1'b1));
    push_word(word_of(FUNC_QUERY_IP, 32'sh0001_0000, 8'h01, 8'h00, 32'sd0, -32'sd127, 1'b1));
    // one vector over three dimensions with mixed modes
    push_word(word_of(FUNC_QUERY_L2, 32'sh0002_4000, 8'h33, 8'hCC, -32'sh0000_8000,
                      32'sh0003_0000, 1'b0));
    push_word(word_of(FUNC_CODE_IP, 32'sd0, 8'hC3, 8'h3C, 32'sh0000_4000, -32'sh0005_0000,
                      1'b0));
    push_word(word_of(FUNC_CODE_L2, 32'sd0, 8'h01, 8'hFE, -32'sh0002_0000, 32'sh0004_0000,
                      1'b1));
    drain_pause();

    // result side holds off while words keep coming, so both queues fill
    hold_off_go = 1'b1;
    for (int i = 0; i < PRESSURE_WORDS; i++)
      push_word(make_word(func_t'($urandom_range(0, 3)),
                          (i == PRESSURE_WORDS - 1) || ($urandom_range(0, 1) == 1)));
    drain_pause();

    // long vector of max-size squares, then one large negative product
    for (int i = 0; i < SAT_WORDS; i++)
      push_word(word_of(FUNC_QUERY_L2, DATA_MIN, 8'hFF, pick_code(), 32'sd0, DATA_MAX, 1'b0));
    push_word(word_of(FUNC_QUERY_IP, DATA_MIN, 8'hFF, 8'h00, 32'sd0, DATA_MAX, 1'b1));
    // short vector right after: sum starts from zero again
    push_word(word_of(FUNC_CODE_L2, 32'sd0, 8'h10, 8'h20, 32'sd0, 32'sh0001_0000, 1'b1));
    drain_pause();

    // random vectors: mostly one mode per vector, a few with the mode changing per word
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent >= RANDOM_WORDS - CALM_WORDS) jitter_on = 1'b0;
      else if ($urandom_range(0, 3) == 0) jitter_on = !jitter_on;
      vec_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      mixed    = ($urandom_range(0, 6) == 0);
      vec_func = func_t'($urandom_range(0, 3));
      for (int d = 0; d < vec_len; d++) begin
        w = make_word(mixed ? func_t'($urandom_range(0, 3)) : vec_func, d == vec_len - 1);
        push_word(w);
        sent++;
        maybe_gap();
      end
      if (jitter_on && $urandom_range(0, 19) == 0) drain_pause();
    end

    // let everything outstanding come back, then a short tail for stray results
    in_push <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/sq8vd_pkg.sv
hdl/sq8vd_fifo.sv
hdl/sq8vd_front.sv
hdl/sq8vd_back.sv
hdl/sq8_vector_distance_core.sv
verif/sq8_vector_distance_checker.sv
verif/tb_sq8_vector_distance_core.sv
